@@ design/csc_pkg.sv @@
// Package for the C-style comment stripper: character codes, scan modes,
// the job record passed from front to back, and queue sizing.
// Depends on nothing; every design file uses it by scoped names.
package csc_pkg;

  localparam int CHAR_BITS = 16;

  localparam logic [CHAR_BITS-1:0] CH_SLASH  = CHAR_BITS'(8'h2F);
  localparam logic [CHAR_BITS-1:0] CH_STAR   = CHAR_BITS'(8'h2A);
  localparam logic [CHAR_BITS-1:0] CH_QUOTE  = CHAR_BITS'(8'h22);
  localparam logic [CHAR_BITS-1:0] CH_BSLASH = CHAR_BITS'(8'h5C);
  localparam logic [CHAR_BITS-1:0] CH_NL     = CHAR_BITS'(8'h0A);

  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_CODE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_LINE   = 2'd2,
    MODE_BLOCK  = 2'd3
  } scan_mode_t;

  // One accepted character that produces output. A two-result job always
  // starts with a released slash, so only the second character is stored.
  typedef struct packed {
    logic                 two;
    logic [CHAR_BITS-1:0] ch;
    logic                 cv;
    logic                 last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jq_status_t;

endpackage

@@ design/csc_front.sv @@
// Front end of the comment stripper: holds the scan state, classifies each
// accepted character and turns it into a job record for the back end.
// Depends on csc_pkg.
module csc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [csc_pkg::CHAR_BITS-1:0] text_char,
  input  logic                         is_last,
  output logic                         job_emit,
  output csc_pkg::job_t                job
);

  csc_pkg::scan_mode_t mode_r, mode_nxt;
  logic slash_r, slash_nxt;
  logic star_r, star_nxt;
  logic esc_r, esc_nxt;

  // Next state.
  always_comb begin
    mode_nxt  = mode_r;
    slash_nxt = slash_r;
    star_nxt  = star_r;
    esc_nxt   = esc_r;
    unique case (mode_r)
      csc_pkg::MODE_CODE: begin
        if (slash_r) begin
          slash_nxt = 1'b0;
          if (text_char == csc_pkg::CH_SLASH) begin
            mode_nxt = csc_pkg::MODE_LINE;
          end else if (text_char == csc_pkg::CH_STAR) begin
            mode_nxt = csc_pkg::MODE_BLOCK;
            star_nxt = 1'b0;
          end else if (text_char == csc_pkg::CH_QUOTE) begin
            mode_nxt = csc_pkg::MODE_STRING;
            esc_nxt  = 1'b0;
          end
        end else if (text_char == csc_pkg::CH_QUOTE) begin
          mode_nxt = csc_pkg::MODE_STRING;
          esc_nxt  = 1'b0;
        end else if (text_char == csc_pkg::CH_SLASH && !is_last) begin
          slash_nxt = 1'b1;
        end
      end
      csc_pkg::MODE_STRING: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (text_char == csc_pkg::CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (text_char == csc_pkg::CH_QUOTE) begin
          mode_nxt = csc_pkg::MODE_CODE;
        end
      end
      csc_pkg::MODE_LINE: begin
        if (text_char == csc_pkg::CH_NL) begin
          mode_nxt = csc_pkg::MODE_CODE;
        end
      end
      csc_pkg::MODE_BLOCK: begin
        if (star_r && text_char == csc_pkg::CH_SLASH) begin
          mode_nxt = csc_pkg::MODE_CODE;
          star_nxt = 1'b0;
        end else begin
          star_nxt = (text_char == csc_pkg::CH_STAR);
        end
      end
      default: mode_nxt = csc_pkg::MODE_CODE;
    endcase
    // The last character of a text returns everything to the start state.
    if (is_last) begin
      mode_nxt  = csc_pkg::MODE_CODE;
      slash_nxt = 1'b0;
      star_nxt  = 1'b0;
      esc_nxt   = 1'b0;
    end
  end

  // Job output.
  always_comb begin
    logic put;
    put      = 1'b0;
    job.two  = 1'b0;
    job.ch   = text_char;
    job.cv   = 1'b1;
    job.last = is_last;
    unique case (mode_r)
      csc_pkg::MODE_CODE: begin
        if (slash_r) begin
          if (text_char != csc_pkg::CH_SLASH && text_char != csc_pkg::CH_STAR) begin
            put     = 1'b1;
            job.two = 1'b1;
          end
        end else begin
          put = !(text_char == csc_pkg::CH_SLASH && !is_last);
        end
      end
      csc_pkg::MODE_STRING: put = 1'b1;
      csc_pkg::MODE_LINE:   put = (text_char == csc_pkg::CH_NL);
      csc_pkg::MODE_BLOCK:  put = 1'b0;
      default:              put = 1'b0;
    endcase
    // A text that ends with nothing to show still gets a bare end marker.
    if (is_last && !put) begin
      job.ch = '0;
      job.cv = 1'b0;
    end
    job_emit = accept && (put || is_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= csc_pkg::MODE_CODE;
      slash_r <= 1'b0;
      star_r  <= 1'b0;
      esc_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      slash_r <= slash_nxt;
      star_r  <= star_nxt;
      esc_r   <= esc_nxt;
    end
  end

endmodule

@@ design/csc_jobq.sv @@
// Short job queue that decouples the front end from the back end.
// Depends on csc_pkg.
module csc_jobq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                enq,
  input  csc_pkg::job_t       enq_job,
  input  logic                deq,
  output csc_pkg::job_t       head_job,
  output csc_pkg::jq_status_t status
);

  csc_pkg::job_t                mem_r [csc_pkg::JQ_DEPTH];
  logic [csc_pkg::JQ_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [csc_pkg::JQ_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [csc_pkg::JQ_CW-1:0]    cnt_r, cnt_nxt;
  logic                         do_enq, do_deq;

  assign status.full  = (cnt_r == csc_pkg::JQ_CW'(csc_pkg::JQ_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_enq = enq && !status.full;
  assign do_deq = deq && !status.empty;
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_enq) begin
      wr_ptr_nxt = (wr_ptr_r == csc_pkg::JQ_AW'(csc_pkg::JQ_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (do_deq) begin
      rd_ptr_nxt = (rd_ptr_r == csc_pkg::JQ_AW'(csc_pkg::JQ_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (do_enq && !do_deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_deq && !do_enq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem_r[wr_ptr_r] <= enq_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ design/csc_back.sv @@
// Back end of the comment stripper: expands each job into one or two
// results and holds the oldest result in the output register.
// Depends on csc_pkg.
module csc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  csc_pkg::job_t                head_job,
  input  csc_pkg::jq_status_t          q_status,
  output logic                         deq,
  input  logic                         pop,
  output logic                         empty,
  output logic [csc_pkg::CHAR_BITS-1:0] out_char,
  output logic                         char_valid,
  output logic                         run_last,
  output logic                         text_end
);

  logic                         out_v_r, out_v_nxt;
  logic                         sel_r, sel_nxt;
  logic [csc_pkg::CHAR_BITS-1:0] ch_r, ch_nxt;
  logic                         cv_r, cv_nxt;
  logic                         rl_r, rl_nxt;
  logic                         te_r, te_nxt;
  logic                         load;

  // The output register can take a new result when it is empty or drained.
  assign load = !q_status.empty && (!out_v_r || pop);

  always_comb begin
    out_v_nxt = out_v_r && !pop;
    sel_nxt   = sel_r;
    ch_nxt    = ch_r;
    cv_nxt    = cv_r;
    rl_nxt    = rl_r;
    te_nxt    = te_r;
    deq       = 1'b0;
    if (load) begin
      out_v_nxt = 1'b1;
      if (head_job.two && !sel_r) begin
        // First half of a two-result job: the held slash is released.
        ch_nxt  = csc_pkg::CH_SLASH;
        cv_nxt  = 1'b1;
        rl_nxt  = 1'b0;
        te_nxt  = 1'b0;
        sel_nxt = 1'b1;
      end else begin
        ch_nxt  = head_job.ch;
        cv_nxt  = head_job.cv;
        rl_nxt  = 1'b1;
        te_nxt  = head_job.last;
        sel_nxt = 1'b0;
        deq     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
    cv_r <= cv_nxt;
    rl_r <= rl_nxt;
    te_r <= te_nxt;
  end

  assign empty      = !out_v_r;
  assign out_char   = ch_r;
  assign char_valid = cv_r;
  assign run_last   = rl_r;
  assign text_end   = te_r;

endmodule

@@ design/c_style_comment_stripper.sv @@
// Top level of the C-style comment stripper: front end, job queue, back end.
// Depends on csc_pkg, csc_front, csc_jobq and csc_back.
//
//  channel | handshake        | payload
//  --------+------------------+---------------------------------------------
//  input   | in_push, in_full | in_text_char[15:0], in_is_last
//  result  | out_pop, out_empty | out_char[15:0], out_char_valid,
//          |                  | out_run_last, out_text_end
//
// One character is taken per cycle while the job queue is not full. A character
// taken is written into the job queue in the same cycle if it gives a job, and
// results are loaded from the queue head into the output register whenever that
// register is empty or popped. A character that releases a held slash gives two
// results, the slash and then the character, through the single output register.
// The four-entry job queue absorbs those bursts and any stall on the result side;
// in_full rises only once it is full. Reset is synchronous and clears the scan
// state, the queue and the valid flag of the output register.
module c_style_comment_stripper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_text_char,
  input  logic        in_is_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_char,
  output logic        out_char_valid,
  output logic        out_run_last,
  output logic        out_text_end
);

  csc_pkg::jq_status_t q_status;
  csc_pkg::job_t       new_job;
  csc_pkg::job_t       head_job;
  logic                job_emit;
  logic                job_deq;
  logic                accept;

  assign in_full = q_status.full;
  assign accept  = in_push && !q_status.full;

  csc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_char (in_text_char),
    .is_last   (in_is_last),
    .job_emit  (job_emit),
    .job       (new_job)
  );

  csc_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .enq      (job_emit),
    .enq_job  (new_job),
    .deq      (job_deq),
    .head_job (head_job),
    .status   (q_status)
  );

  csc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .q_status   (q_status),
    .deq        (job_deq),
    .pop        (out_pop),
    .empty      (out_empty),
    .out_char   (out_char),
    .char_valid (out_char_valid),
    .run_last   (out_run_last),
    .text_end   (out_text_end)
  );

endmodule

@@ design/csc_checker.sv @@
// Port-level checks for the C-style comment stripper and the bind that
// attaches them to the top level. Depends on csc_pkg.
module csc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [15:0] out_char,
  input logic        out_char_valid,
  input logic        out_run_last,
  input logic        out_text_end
);

  // A bare end marker carries no character and closes both the item and text.
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_char_valid) |-> (out_char == '0 && out_run_last && out_text_end))
    else $error("bare end marker with bad fields");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_text_end) |-> out_run_last)
    else $error("text end without run last");

  // Only a released slash can be the first of two results.
  a_first_is_slash: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_run_last) |-> (out_char_valid && out_char == 16'(csc_pkg::CH_SLASH)))
    else $error("first of two results is not a slash");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result shown right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_char) && $stable(out_run_last)))
    else $error("stalled result changed");

endmodule

bind c_style_comment_stripper csc_checker u_csc_checker (.*);

@@ tb/tb_c_style_comment_stripper.sv @@
// Testbench for c_style_comment_stripper: directed and token-based random texts,
// checked against a behavioral scan-mode predictor held in a scoreboard class.
// Depends on csc_pkg and the c_style_comment_stripper RTL.
module tb_c_style_comment_stripper;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] ch;
    logic        cv;
    logic        rl;
    logic        te;
  } strip_out_t;

  class strip_scoreboard;
    csc_pkg::scan_mode_t mode;
    bit         slash_held;
    bit         star_seen;
    bit         esc;
    strip_out_t kept_q[$];
    strip_out_t step_q[$];
    int         errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode       = csc_pkg::MODE_CODE;
      slash_held = 1'b0;
      star_seen  = 1'b0;
      esc        = 1'b0;
    endfunction

    task report(input string msg);
      if (errors < 100) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void emit(input logic [15:0] c);
      strip_out_t r;
      r.ch = c;
      r.cv = 1'b1;
      r.rl = 1'b0;
      r.te = 1'b0;
      if (step_q.size() < 2) step_q.push_back(r);
    endfunction

    // Character in code with no slash held before it.
    function void code_char(input logic [15:0] c, input logic l);
      if (c == csc_pkg::CH_QUOTE) begin
        mode = csc_pkg::MODE_STRING;
        esc  = 1'b0;
        emit(c);
      end else if (c == csc_pkg::CH_SLASH && !l) begin
        slash_held = 1'b1;
      end else begin
        emit(c);
      end
    endfunction

    function void note_input(input logic [15:0] c, input logic l);
      strip_out_t bare;
      step_q.delete();
      case (mode)
        csc_pkg::MODE_CODE: begin
          if (slash_held) begin
            slash_held = 1'b0;
            if (c == csc_pkg::CH_SLASH) begin
              mode = csc_pkg::MODE_LINE;
            end else if (c == csc_pkg::CH_STAR) begin
              mode      = csc_pkg::MODE_BLOCK;
              star_seen = 1'b0;
            end else begin
              emit(csc_pkg::CH_SLASH);
              code_char(c, l);
            end
          end else begin
            code_char(c, l);
          end
        end
        csc_pkg::MODE_STRING: begin
          emit(c);
          if (esc) esc = 1'b0;
          else if (c == csc_pkg::CH_BSLASH) esc = 1'b1;
          else if (c == csc_pkg::CH_QUOTE) mode = csc_pkg::MODE_CODE;
        end
        csc_pkg::MODE_LINE: begin
          if (c == csc_pkg::CH_NL) begin
            mode = csc_pkg::MODE_CODE;
            emit(c);
          end
        end
        default: begin
          if (star_seen && c == csc_pkg::CH_SLASH) begin
            mode      = csc_pkg::MODE_CODE;
            star_seen = 1'b0;
          end else begin
            star_seen = (c == csc_pkg::CH_STAR);
          end
        end
      endcase
      if (l) begin
        if (step_q.size() == 0) begin
          bare = '0;
          step_q.push_back(bare);
        end
        step_q[step_q.size()-1].te = 1'b1;
        clear_state();
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].rl = 1'b1;
      foreach (step_q[i]) kept_q.push_back(step_q[i]);
    endfunction

    task check_result(input strip_out_t got);
      strip_out_t want;
      if (kept_q.size() == 0) begin
        report($sformatf("unexpected result char %h", got.ch));
      end else begin
        want = kept_q.pop_front();
        if (got.ch !== want.ch)
          report($sformatf("out_char %h, predicted %h", got.ch, want.ch));
        if (got.cv !== want.cv)
          report($sformatf("out_char_valid %b, predicted %b", got.cv, want.cv));
        if (got.rl !== want.rl)
          report($sformatf("out_run_last %b, predicted %b", got.rl, want.rl));
        if (got.te !== want.te)
          report($sformatf("out_text_end %b, predicted %b", got.te, want.te));
      end
    endtask

    function int pending();
      return kept_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_text_char = '0;
  logic        in_is_last = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_char;
  logic        out_char_valid;
  logic        out_run_last;
  logic        out_text_end;

  strip_scoreboard sb = new();
  int          send_idle_pct = 31;
  int          recv_idle_pct = 62;
  int          chars_sent;
  logic [15:0] text_q[$];

  c_style_comment_stripper dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_text_char(in_text_char),
    .in_is_last(in_is_last),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_char(out_char),
    .out_char_valid(out_char_valid),
    .out_run_last(out_run_last),
    .out_text_end(out_text_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Both transfers are taken from values that settled at the previous falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) sb.note_input(in_text_char, in_is_last);
      if (out_pop && !out_empty)
        sb.check_result({out_char, out_char_valid, out_run_last, out_text_end});
    end
  end

  always @(negedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_char(input logic [15:0] c, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push      <= 1'b1;
    in_text_char <= c;
    in_is_last   <= l;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic logic [15:0] printable();
    return 16'h0020 + 16'($urandom_range(94));
  endfunction

  // Appends one lexical piece; about one in ten comments or strings is left open.
  function automatic void add_token();
    int n;
    bit open_end;
    n = $urandom_range(4);
    open_end = ($urandom_range(9) == 0);
    case ($urandom_range(5))
      0: begin
        if ($urandom_range(1)) text_q.push_back(printable());
        else text_q.push_back(16'($urandom_range(65535)));
      end
      1: begin
        text_q.push_back(csc_pkg::CH_QUOTE);
        repeat (n) begin
          if ($urandom_range(3) == 0) begin
            text_q.push_back(csc_pkg::CH_BSLASH);
            text_q.push_back($urandom_range(1) ? csc_pkg::CH_QUOTE : printable());
          end else begin
            text_q.push_back(printable());
          end
        end
        if (!open_end) text_q.push_back(csc_pkg::CH_QUOTE);
      end
      2: begin
        text_q.push_back(csc_pkg::CH_SLASH);
        text_q.push_back(csc_pkg::CH_SLASH);
        repeat (n) text_q.push_back(printable());
        if (!open_end) text_q.push_back(csc_pkg::CH_NL);
      end
      3: begin
        text_q.push_back(csc_pkg::CH_SLASH);
        text_q.push_back(csc_pkg::CH_STAR);
        repeat (n) begin
          case ($urandom_range(3))
            0: text_q.push_back(csc_pkg::CH_STAR);
            1: text_q.push_back(csc_pkg::CH_SLASH);
            default: text_q.push_back(printable());
          endcase
        end
        if (!open_end) begin
          text_q.push_back(csc_pkg::CH_STAR);
          text_q.push_back(csc_pkg::CH_SLASH);
        end
      end
      4: begin
        case ($urandom_range(4))
          0: text_q.push_back(csc_pkg::CH_SLASH);
          1: text_q.push_back(csc_pkg::CH_STAR);
          2: text_q.push_back(csc_pkg::CH_QUOTE);
          3: text_q.push_back(csc_pkg::CH_BSLASH);
          default: text_q.push_back(csc_pkg::CH_NL);
        endcase
      end
      default: text_q.push_back(printable());
    endcase
  endfunction

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int phase_start;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Held slash before a letter and before a quote, escaped quote, code extremes.
    text_q = '{16'h0000, csc_pkg::CH_SLASH, 16'h0078, csc_pkg::CH_SLASH,
               csc_pkg::CH_QUOTE, csc_pkg::CH_BSLASH, csc_pkg::CH_QUOTE,
               16'h007A, csc_pkg::CH_QUOTE, 16'hFFFF};
    send_text();
    // Line comment keeps its newline; a slash on the last character goes out at once.
    text_q = '{csc_pkg::CH_SLASH, csc_pkg::CH_SLASH, 16'h0063, csc_pkg::CH_NL,
               csc_pkg::CH_SLASH};
    send_text();
    // The star of the opener cannot close the block comment.
    text_q = '{csc_pkg::CH_SLASH, csc_pkg::CH_STAR, csc_pkg::CH_SLASH,
               csc_pkg::CH_STAR, csc_pkg::CH_STAR, csc_pkg::CH_SLASH, 16'h006B};
    send_text();
    // Text ending inside a block comment gives a bare end marker.
    text_q = '{csc_pkg::CH_SLASH, csc_pkg::CH_STAR, 16'h0071};
    send_text();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 31 : 0;
      phase_start = chars_sent;
      while (chars_sent - phase_start < 560) begin
        repeat ($urandom_range(1, 8)) add_token();
        send_text();
      end
      in_push <= 1'b0;
      @(negedge clk);
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
